@@ rtl/core/closed_polyline_arc_projection_macros.svh @@
// assertion macros used by the checker
`ifndef CLOSED_POLYLINE_ARC_PROJECTION_MACROS_SVH
`define CLOSED_POLYLINE_ARC_PROJECTION_MACROS_SVH

// same-cycle implication
`define CPAP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("cpap assertion failed");

// next-cycle implication
`define CPAP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("cpap assertion failed");

`endif

@@ rtl/core/cpap_pkg.sv @@
package cpap_pkg;

	localparam int MAX_STATIONS_DEF = 1024;
	localparam int MIN_STATIONS_DEF = 3;

	// operand width of the shared multiplier
	localparam int MUL_W = 35;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_CLOSE  = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_NOLOAD = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

endpackage

@@ rtl/core/cpap_if.sv @@
interface cpap_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_z;
	logic [9:0]        hint_station;

	modport source (output valid, output op, output pos_x, output pos_z,
		output hint_station, input ready);
	modport sink (input valid, input op, input pos_x, input pos_z,
		input hint_station, output ready);
endinterface

interface cpap_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] arc_result;
	logic [1:0]  status;

	modport source (output valid, output arc_result, output status, input ready);
	modport sink (input valid, input arc_result, input status, output ready);
endinterface

@@ rtl/core/cpap_ram.sv @@
module cpap_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/cpap_mul.sv @@
module cpap_mul
	import cpap_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [MUL_W-1:0]   a,
	input  logic signed [MUL_W-1:0]   b,
	output logic                      done,
	output logic signed [2*MUL_W-1:0] p
);

	localparam int IT_W = $clog2(MUL_W);

	logic [2*MUL_W-1:0] acc_q;
	logic [2*MUL_W-1:0] mcand_q;
	logic [MUL_W-1:0]   mplier_q;
	logic [IT_W-1:0]    it_q;
	logic               neg_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_W-1:0]   mag_a;
	logic [MUL_W-1:0]   mag_b;

	assign mag_a = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
	assign mag_b = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);

	// shift-add over magnitudes, one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			it_q     <= '0;
			neg_q    <= 1'b0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
		end else if (start) begin
			acc_q    <= '0;
			mcand_q  <= (2*MUL_W)'(mag_a);
			mplier_q <= mag_b;
			it_q     <= '0;
			neg_q    <= a[MUL_W-1] ^ b[MUL_W-1];
			busy_q   <= 1'b1;
			done_q   <= 1'b0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[2*MUL_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MUL_W-1:1]};
			it_q     <= it_q + 1'b1;
			if (it_q == IT_W'(MUL_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign p    = neg_q ? $signed(-acc_q) : $signed(acc_q);

endmodule

@@ rtl/core/closed_polyline_arc_projection.sv @@
// Closed polyline arc projection. Stations (x, z, running arc) sit in one
// synchronous RAM; chord lengths come from a bit-serial square root, products
// from one shared shift-add multiplier, which sets the pace. One item is
// worked at a time. A query searches 2 * hint_window segments.
// Results wait in an output register, so the next item is taken while the
// last result is still pending.
// No clearing pass after reset; unwritten stations are never read.
module closed_polyline_arc_projection
	import cpap_pkg::*;
#(
	parameter int MAX_STATIONS = MAX_STATIONS_DEF,
	parameter int MIN_STATIONS = MIN_STATIONS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata,
	cpap_req_if.sink   req,
	cpap_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(MAX_STATIONS);
	localparam int CNT_W = $clog2(MAX_STATIONS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RA, S_RB, S_RC, S_SQ0, S_MUL, S_SQRT, S_DIV,
		S_MOD, S_HRD, S_HCAP, S_NEXT, S_WR, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		M_UXX, M_UZZ, M_DOTX, M_DOTZ, M_PX, M_PZ, M_EX, M_EZ, M_ARC
	} mop_t;

	typedef enum logic [1:0] {MT_HINT, MT_WIN, MT_ARC} modt_t;

	state_t state_q;
	mop_t   mop_q;
	modt_t  modt_q;

	logic [9:0]         hint_window_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [31:0]        lap_q;
	logic               closed_q;

	logic [1:0]         op_q;
	logic signed [31:0] px_q;
	logic signed [31:0] pz_q;

	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   h_q;
	logic [10:0]        steps_q;

	logic signed [31:0] ax_q;
	logic signed [31:0] az_q;
	logic [31:0]        arci_q;
	logic signed [32:0] ux_q;
	logic signed [32:0] uz_q;
	logic signed [32:0] dpx_q;
	logic signed [32:0] dpz_q;
	logic [67:0]        lensq_q;
	logic signed [67:0] dot_q;
	logic [16:0]        t_q;
	logic [68:0]        div_r_q;
	logic signed [34:0] ex_q;
	logic signed [34:0] ez_q;
	logic [67:0]        dist_q;
	logic [67:0]        best_d_q;
	logic               have_q;
	logic [31:0]        best_arc_q;

	logic [67:0]        sq_rad_q;
	logic [35:0]        sq_rem_q;
	logic [33:0]        sq_root_q;

	logic [34:0]        mod_num_q;
	logic [31:0]        mod_den_q;
	logic [31:0]        mod_rem_q;

	logic [5:0]         it_q;

	logic [31:0]        res_arc_q;
	logic [1:0]         res_st_q;
	logic               rsp_valid_q;
	logic [31:0]        rsp_arc_q;
	logic [1:0]         rsp_st_q;

	logic                      mul_go_q;
	logic signed [MUL_W-1:0]   mul_a_q;
	logic signed [MUL_W-1:0]   mul_b_q;
	logic                      mul_done;
	logic signed [2*MUL_W-1:0] mul_p;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_raddr;
	logic [95:0]        ram_rdata;
	logic signed [31:0] rd_x;
	logic signed [31:0] rd_z;
	logic [31:0]        rd_arc;
	logic [IDX_W-1:0]   idx_nx;

	logic [32:0]        mod_trial;
	logic               mod_ge;
	logic [31:0]        mod_rem_nx;
	logic [35:0]        sq_trem;
	logic [35:0]        sq_trial;
	logic               sq_ge;
	logic [35:0]        sq_rem_nx;
	logic [33:0]        sq_root_nx;
	logic [68:0]        div_sh;
	logic               div_ge;
	logic [68:0]        div_r_nx;
	logic [16:0]        t_nx;
	logic [67:0]        lensq_sum;
	logic signed [67:0] dot_sum;
	logic [67:0]        dist_sum;
	logic signed [35:0] ex_w;
	logic [34:0]        arc_w;
	logic [34:0]        chord_w;
	logic [CNT_W:0]     start_w;

	cpap_ram #(.WIDTH(96), .DEPTH(MAX_STATIONS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata ({px_q, pz_q, res_arc_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cpap_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign rd_x   = $signed(ram_rdata[95:64]);
	assign rd_z   = $signed(ram_rdata[63:32]);
	assign rd_arc = ram_rdata[31:0];
	assign ram_we = (state_q == S_WR);

	assign idx_nx = (CNT_W'(idx_q) + 1'b1 == cnt_q) ? '0 : idx_q + 1'b1;

	always_comb begin
		case (state_q)
			S_RB:    ram_raddr = idx_nx;
			S_HRD:   ram_raddr = h_q;
			default: ram_raddr = idx_q;
		endcase
	end

	// restoring remainder step
	assign mod_trial  = {mod_rem_q, mod_num_q[34]};
	assign mod_ge     = mod_trial >= {1'b0, mod_den_q};
	assign mod_rem_nx = mod_ge ? 32'(mod_trial - {1'b0, mod_den_q}) : mod_trial[31:0];

	// square root digit step
	assign sq_trem    = {sq_rem_q[33:0], sq_rad_q[67:66]};
	assign sq_trial   = {sq_root_q, 2'b01};
	assign sq_ge      = sq_trem >= sq_trial;
	assign sq_rem_nx  = sq_ge ? sq_trem - sq_trial : sq_trem;
	assign sq_root_nx = {sq_root_q[32:0], sq_ge};

	// projection parameter quotient step
	assign div_sh   = {div_r_q[67:0], 1'b0};
	assign div_ge   = div_sh >= {1'b0, lensq_q};
	assign div_r_nx = div_ge ? div_sh - {1'b0, lensq_q} : div_sh;
	assign t_nx     = {t_q[15:0], div_ge};

	assign lensq_sum = lensq_q + mul_p[67:0];
	assign dot_sum   = dot_q + $signed(mul_p[67:0]);
	assign dist_sum  = dist_q + mul_p[67:0];
	assign ex_w      = 36'(px_q) - 36'(ax_q) - $signed(mul_p[51:16]);
	assign arc_w     = {3'b000, arci_q} + {1'b0, mul_p[49:16]};
	assign chord_w   = {3'b000, arci_q} + {1'b0, sq_root_nx};
	assign start_w   = ((CNT_W+1)'(h_q) >= (CNT_W+1)'(mod_rem_nx))
		? (CNT_W+1)'(h_q) - (CNT_W+1)'(mod_rem_nx)
		: (CNT_W+1)'(h_q) + (CNT_W+1)'(cnt_q) - (CNT_W+1)'(mod_rem_nx);

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.arc_result = rsp_arc_q;
	assign rsp.status     = rsp_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mop_q         <= M_UXX;
			modt_q        <= MT_HINT;
			hint_window_q <= 10'd2;
			cnt_q         <= '0;
			lap_q         <= '0;
			closed_q      <= 1'b0;
			op_q          <= OP_CLEAR;
			px_q          <= '0;
			pz_q          <= '0;
			idx_q         <= '0;
			h_q           <= '0;
			steps_q       <= '0;
			ax_q          <= '0;
			az_q          <= '0;
			arci_q        <= '0;
			ux_q          <= '0;
			uz_q          <= '0;
			dpx_q         <= '0;
			dpz_q         <= '0;
			lensq_q       <= '0;
			dot_q         <= '0;
			t_q           <= '0;
			div_r_q       <= '0;
			ex_q          <= '0;
			ez_q          <= '0;
			dist_q        <= '0;
			best_d_q      <= '0;
			have_q        <= 1'b0;
			best_arc_q    <= '0;
			sq_rad_q      <= '0;
			sq_rem_q      <= '0;
			sq_root_q     <= '0;
			mod_num_q     <= '0;
			mod_den_q     <= '0;
			mod_rem_q     <= '0;
			it_q          <= '0;
			res_arc_q     <= '0;
			res_st_q      <= ST_OK;
			rsp_valid_q   <= 1'b0;
			rsp_arc_q     <= '0;
			rsp_st_q      <= ST_OK;
			mul_go_q      <= 1'b0;
			mul_a_q       <= '0;
			mul_b_q       <= '0;
		end else begin
			mul_go_q <= 1'b0;
			if (cfg_we) begin
				hint_window_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q      <= req.op;
						px_q      <= req.pos_x;
						pz_q      <= req.pos_z;
						res_arc_q <= '0;
						res_st_q  <= ST_OK;
						idx_q     <= IDX_W'(cnt_q - 1'b1);
						case (req.op)
							OP_CLEAR: begin
								cnt_q    <= '0;
								lap_q    <= '0;
								closed_q <= 1'b0;
								state_q  <= S_DONE;
							end
							OP_APPEND: begin
								if (cnt_q >= CNT_W'(MAX_STATIONS)) begin
									res_st_q <= ST_FULL;
									state_q  <= S_DONE;
								end else if (cnt_q == '0) begin
									state_q <= S_WR;
								end else begin
									state_q <= S_RA;
								end
							end
							OP_CLOSE: begin
								if (cnt_q < CNT_W'(MIN_STATIONS)) begin
									res_st_q <= ST_NOLOAD;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_RA;
								end
							end
							default: begin
								if (!closed_q || cnt_q < CNT_W'(MIN_STATIONS)) begin
									res_st_q <= ST_NOLOAD;
									state_q  <= S_DONE;
								end else begin
									mod_num_q <= 35'(req.hint_station);
									mod_den_q <= 32'(cnt_q);
									mod_rem_q <= '0;
									it_q      <= '0;
									modt_q    <= MT_HINT;
									state_q   <= S_MOD;
								end
							end
						endcase
					end
				end

				S_RA: begin
					state_q <= S_RB;
				end

				S_RB: begin
					ax_q   <= rd_x;
					az_q   <= rd_z;
					arci_q <= rd_arc;
					if (op_q == OP_APPEND) begin
						ux_q    <= 33'(px_q) - 33'(rd_x);
						uz_q    <= 33'(pz_q) - 33'(rd_z);
						state_q <= S_SQ0;
					end else begin
						state_q <= S_RC;
					end
				end

				S_RC: begin
					ux_q    <= 33'(rd_x) - 33'(ax_q);
					uz_q    <= 33'(rd_z) - 33'(az_q);
					dpx_q   <= 33'(px_q) - 33'(ax_q);
					dpz_q   <= 33'(pz_q) - 33'(az_q);
					state_q <= S_SQ0;
				end

				S_SQ0: begin
					mul_a_q  <= MUL_W'(ux_q);
					mul_b_q  <= MUL_W'(ux_q);
					mop_q    <= M_UXX;
					mul_go_q <= 1'b1;
					state_q  <= S_MUL;
				end

				S_MUL: begin
					if (mul_done) begin
						case (mop_q)
							M_UXX: begin
								lensq_q  <= mul_p[67:0];
								mul_a_q  <= MUL_W'(uz_q);
								mul_b_q  <= MUL_W'(uz_q);
								mop_q    <= M_UZZ;
								mul_go_q <= 1'b1;
							end
							M_UZZ: begin
								lensq_q <= lensq_sum;
								if (op_q != OP_QUERY) begin
									sq_rad_q  <= lensq_sum;
									sq_rem_q  <= '0;
									sq_root_q <= '0;
									it_q      <= '0;
									state_q   <= S_SQRT;
								end else if (lensq_sum == '0) begin
									state_q <= S_NEXT;
								end else begin
									mul_a_q  <= MUL_W'(dpx_q);
									mul_b_q  <= MUL_W'(ux_q);
									mop_q    <= M_DOTX;
									mul_go_q <= 1'b1;
								end
							end
							M_DOTX: begin
								dot_q    <= $signed(mul_p[67:0]);
								mul_a_q  <= MUL_W'(dpz_q);
								mul_b_q  <= MUL_W'(uz_q);
								mop_q    <= M_DOTZ;
								mul_go_q <= 1'b1;
							end
							M_DOTZ: begin
								if (dot_sum[67] || dot_sum == '0) begin
									t_q      <= '0;
									mul_a_q  <= MUL_W'(ux_q);
									mul_b_q  <= '0;
									mop_q    <= M_PX;
									mul_go_q <= 1'b1;
								end else if ($unsigned(dot_sum) >= lensq_q) begin
									t_q      <= 17'h10000;
									mul_a_q  <= MUL_W'(ux_q);
									mul_b_q  <= MUL_W'(17'h10000);
									mop_q    <= M_PX;
									mul_go_q <= 1'b1;
								end else begin
									div_r_q <= {1'b0, $unsigned(dot_sum)};
									t_q     <= '0;
									it_q    <= '0;
									state_q <= S_DIV;
								end
							end
							M_PX: begin
								ex_q     <= ex_w[34:0];
								mul_a_q  <= MUL_W'(uz_q);
								mul_b_q  <= $signed({18'd0, t_q});
								mop_q    <= M_PZ;
								mul_go_q <= 1'b1;
							end
							M_PZ: begin
								ez_q     <= 35'(36'(pz_q) - 36'(az_q) - $signed(mul_p[51:16]));
								mul_a_q  <= ex_q;
								mul_b_q  <= ex_q;
								mop_q    <= M_EX;
								mul_go_q <= 1'b1;
							end
							M_EX: begin
								dist_q   <= mul_p[67:0];
								mul_a_q  <= ez_q;
								mul_b_q  <= ez_q;
								mop_q    <= M_EZ;
								mul_go_q <= 1'b1;
							end
							M_EZ: begin
								if (!have_q || dist_sum < best_d_q) begin
									have_q    <= 1'b1;
									best_d_q  <= dist_sum;
									sq_rad_q  <= lensq_q;
									sq_rem_q  <= '0;
									sq_root_q <= '0;
									it_q      <= '0;
									state_q   <= S_SQRT;
								end else begin
									state_q <= S_NEXT;
								end
							end
							M_ARC: begin
								if (arc_w >= {3'b000, lap_q}) begin
									if (lap_q == '0) begin
										best_arc_q <= '0;
										state_q    <= S_NEXT;
									end else begin
										mod_num_q <= arc_w;
										mod_den_q <= lap_q;
										mod_rem_q <= '0;
										it_q      <= '0;
										modt_q    <= MT_ARC;
										state_q   <= S_MOD;
									end
								end else begin
									best_arc_q <= arc_w[31:0];
									state_q    <= S_NEXT;
								end
							end
							default: begin
								state_q <= S_NEXT;
							end
						endcase
					end
				end

				S_DIV: begin
					div_r_q <= div_r_nx;
					t_q     <= t_nx;
					it_q    <= it_q + 1'b1;
					if (it_q == 6'd15) begin
						mul_a_q  <= MUL_W'(ux_q);
						mul_b_q  <= $signed({18'd0, t_nx});
						mop_q    <= M_PX;
						mul_go_q <= 1'b1;
						state_q  <= S_MUL;
					end
				end

				S_SQRT: begin
					sq_rad_q  <= {sq_rad_q[65:0], 2'b00};
					sq_rem_q  <= sq_rem_nx;
					sq_root_q <= sq_root_nx;
					it_q      <= it_q + 1'b1;
					if (it_q == 6'd33) begin
						if (op_q == OP_QUERY) begin
							mul_a_q  <= $signed({1'b0, sq_root_nx});
							mul_b_q  <= $signed({18'd0, t_q});
							mop_q    <= M_ARC;
							mul_go_q <= 1'b1;
							state_q  <= S_MUL;
						end else begin
							res_arc_q <= (|chord_w[34:32]) ? '1 : chord_w[31:0];
							res_st_q  <= (|chord_w[34:32]) ? ST_SAT : ST_OK;
							if (op_q == OP_APPEND) begin
								state_q <= S_WR;
							end else begin
								lap_q    <= (|chord_w[34:32]) ? '1 : chord_w[31:0];
								closed_q <= 1'b1;
								state_q  <= S_DONE;
							end
						end
					end
				end

				S_MOD: begin
					mod_num_q <= {mod_num_q[33:0], 1'b0};
					mod_rem_q <= mod_rem_nx;
					it_q      <= it_q + 1'b1;
					if (it_q == 6'd34) begin
						it_q      <= '0;
						mod_rem_q <= '0;
						case (modt_q)
							MT_HINT: begin
								h_q       <= IDX_W'(mod_rem_nx);
								mod_num_q <= 35'(hint_window_q);
								modt_q    <= MT_WIN;
							end
							MT_WIN: begin
								idx_q    <= IDX_W'(start_w);
								steps_q  <= {hint_window_q, 1'b0};
								have_q   <= 1'b0;
								best_d_q <= '0;
								state_q  <= S_HRD;
							end
							default: begin
								best_arc_q <= mod_rem_nx;
								state_q    <= S_NEXT;
							end
						endcase
					end
				end

				S_HRD: begin
					state_q <= S_HCAP;
				end

				S_HCAP: begin
					best_arc_q <= rd_arc;
					if (steps_q == '0) begin
						res_arc_q <= rd_arc;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_RA;
					end
				end

				S_NEXT: begin
					if (steps_q == 11'd1) begin
						res_arc_q <= best_arc_q;
						state_q   <= S_DONE;
					end else begin
						steps_q <= steps_q - 1'b1;
						idx_q   <= idx_nx;
						state_q <= S_RA;
					end
				end

				S_WR: begin
					cnt_q    <= cnt_q + 1'b1;
					closed_q <= 1'b0;
					lap_q    <= '0;
					state_q  <= S_DONE;
				end

				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_arc_q   <= res_arc_q;
						rsp_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/cpap_checker.sv @@
`include "closed_polyline_arc_projection_macros.svh"

module cpap_checker
	import cpap_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_arc_result,
	input logic [1:0]  rsp_status
);

	// one item in flight: ready drops after every transfer
	`CPAP_ASSERT_NXT(a_req_busy, clk, arst_n, req_valid && req_ready, !req_ready)

	// table full and not loaded carry no arc
	`CPAP_ASSERT_IMP(a_err_zero, clk, arst_n,
		rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOLOAD),
		rsp_arc_result == 32'd0)

	`CPAP_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_arc_result) && $stable(rsp_status))

endmodule

bind closed_polyline_arc_projection cpap_checker u_cpap_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_arc_result (rsp.arc_result),
	.rsp_status     (rsp.status)
);

@@ bench/tb_closed_polyline_arc_projection.sv @@
`timescale 1ns / 1ps

module tb_closed_polyline_arc_projection;
	import cpap_pkg::*;

	typedef logic signed [95:0] wide_t;
	typedef struct {
		logic [31:0] arc;
		logic [1:0]  status;
	} arc_answer_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [9:0] cfg_wdata;

	cpap_req_if req ();
	cpap_rsp_if rsp ();

	closed_polyline_arc_projection dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	// predictor state
	int          stn_x [MAX_STATIONS_DEF];
	int          stn_z [MAX_STATIONS_DEF];
	logic [31:0] stn_arc [MAX_STATIONS_DEF];
	int          stn_count;
	logic [31:0] lap_len;
	bit          lap_done;
	int          window;

	arc_answer_t answer_q [$];
	int          errors;
	int          answers_seen;
	int          items_sent;
	int          queries_sent;
	int          src_idle_pct;
	int          snk_idle_pct;
	int          hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("tb_closed_polyline_arc_projection: FAIL");
		$finish;
	end

	function automatic longint unsigned root_of(wide_t v);
		longint unsigned r;
		longint unsigned c;
		wide_t cw;
		r = 0;
		for (int b = 36; b >= 0; b--) begin
			c = r | (64'd1 << b);
			cw = c;
			if (!(v < cw * cw))
				r = c;
		end
		return r;
	endfunction

	function automatic wide_t sum_sq(longint dx, longint dz);
		wide_t a;
		wide_t b;
		a = dx;
		b = dz;
		return a * a + b * b;
	endfunction

	function automatic logic [31:0] project_arc(longint px, longint pz, int hint);
		int n;
		int h;
		int m;
		int i;
		int j;
		longint ax, az, ux, uz, t, ex, ez;
		wide_t len_sq, dot, gap_d, best_d, wa, wb;
		longint unsigned arc, best_arc;
		bit found;
		n = stn_count;
		h = hint % n;
		best_arc = stn_arc[h];
		best_d = 0;
		found = 0;
		for (int s = -window; s < window; s++) begin
			m = (h + s) % n;
			i = (m < 0) ? m + n : m;
			j = (i + 1 == n) ? 0 : i + 1;
			ax = stn_x[i];
			az = stn_z[i];
			ux = longint'(stn_x[j]) - ax;
			uz = longint'(stn_z[j]) - az;
			len_sq = sum_sq(ux, uz);
			if (len_sq == 0)
				continue;
			wa = px - ax;
			wb = pz - az;
			dot = wa * ux + wb * uz;
			if (dot <= 0)
				t = 0;
			else if (dot >= len_sq)
				t = 65536;
			else
				t = longint'((dot <<< 16) / len_sq);
			ex = px - (ax + ((ux * t) >>> 16));
			ez = pz - (az + ((uz * t) >>> 16));
			gap_d = sum_sq(ex, ez);
			if (!found || gap_d < best_d) begin
				found = 1;
				best_d = gap_d;
				arc = longint'(stn_arc[i]) + ((root_of(len_sq) * t) >> 16);
				if (arc >= lap_len)
					arc = (lap_len > 0) ? arc % lap_len : 0;
				best_arc = arc;
			end
		end
		return best_arc[31:0];
	endfunction

	function automatic arc_answer_t predict_item(logic [1:0] op, int x, int z, int hint);
		arc_answer_t a;
		longint unsigned arc;
		int last;
		a.arc = 0;
		a.status = ST_OK;
		case (op)
			OP_CLEAR: begin
				stn_count = 0;
				lap_len = 0;
				lap_done = 0;
			end
			OP_APPEND: begin
				if (stn_count >= MAX_STATIONS_DEF) begin
					a.status = ST_FULL;
				end else begin
					stn_x[stn_count] = x;
					stn_z[stn_count] = z;
					arc = 0;
					if (stn_count > 0)
						arc = longint'(stn_arc[stn_count - 1]) + root_of(sum_sq(
							longint'(x) - stn_x[stn_count - 1],
							longint'(z) - stn_z[stn_count - 1]));
					if (arc > 64'hFFFF_FFFF) begin
						arc = 64'hFFFF_FFFF;
						a.status = ST_SAT;
					end
					stn_arc[stn_count] = arc[31:0];
					a.arc = arc[31:0];
					stn_count++;
					lap_done = 0;
					lap_len = 0;
				end
			end
			OP_CLOSE: begin
				if (stn_count < MIN_STATIONS_DEF) begin
					a.status = ST_NOLOAD;
				end else begin
					last = stn_count - 1;
					arc = longint'(stn_arc[last]) + root_of(sum_sq(
						longint'(stn_x[0]) - stn_x[last],
						longint'(stn_z[0]) - stn_z[last]));
					if (arc > 64'hFFFF_FFFF) begin
						arc = 64'hFFFF_FFFF;
						a.status = ST_SAT;
					end
					lap_len = arc[31:0];
					lap_done = 1;
					a.arc = arc[31:0];
				end
			end
			default: begin
				if (!lap_done || stn_count < MIN_STATIONS_DEF)
					a.status = ST_NOLOAD;
				else
					a.arc = project_arc(x, z, hint);
			end
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
		$display("mismatch on %s at result %0d: expected %0h, got %0h",
			what, answers_seen, exp_v, got_v);
		errors++;
	endtask

	task automatic stash_answer(arc_answer_t a);
		answer_q.insert(answer_q.size(), a);
	endtask

	// result side
	initial begin
		arc_answer_t e;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("unexpected result", 32'd0, rsp.arc_result);
				end else begin
					e = answer_q.pop_front();
					if (rsp.arc_result !== e.arc)
						report_mismatch("arc_result", e.arc, rsp.arc_result);
					if (rsp.status !== e.status)
						report_mismatch("status", e.status, rsp.status);
				end
				answers_seen++;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	task automatic send_item(logic [1:0] op, int x, int z, int hint);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.pos_x <= x;
		req.pos_z <= z;
		req.hint_station <= hint[9:0];
		do @(posedge clk); while (!req.ready);
		stash_answer(predict_item(op, x, z, hint[9:0]));
		items_sent++;
		if (op == OP_QUERY)
			queries_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic set_window(int v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v[9:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		window = v & 10'h3FF;
		@(posedge clk);
	endtask

	task automatic test_unloaded_map();
		send_item(OP_QUERY, 0, 0, 0);
		send_item(OP_CLOSE, 0, 0, 0);
		send_item(OP_APPEND, 256, 256, 0);
		send_item(OP_APPEND, 512, 256, 0);
		send_item(OP_CLOSE, 0, 0, 0);
		send_item(OP_QUERY, 300, 300, 1);
		send_item(OP_CLEAR, 0, 0, 0);
	endtask

	task automatic test_square_loop();
		send_item(OP_APPEND, 0, 0, 0);
		send_item(OP_APPEND, 2560, 0, 0);
		send_item(OP_APPEND, 2560, 0, 0);
		send_item(OP_APPEND, 2560, 2560, 0);
		send_item(OP_APPEND, 0, 2560, 0);
		send_item(OP_CLOSE, 0, 0, 0);
		send_item(OP_QUERY, 1280, 1280, 1);
		send_item(OP_QUERY, -900, -700, 0);
		send_item(OP_QUERY, 3000, 1000, 3);
		send_item(OP_QUERY, 100, 2000, 4);
		send_item(OP_QUERY, 0, 1, 1023);
		// reopen, then query on an open map
		send_item(OP_APPEND, -2560, 1280, 0);
		send_item(OP_QUERY, 0, 0, 0);
		send_item(OP_CLOSE, 0, 0, 0);
	endtask

	task automatic test_window_extremes();
		set_window(0);
		send_item(OP_QUERY, 1000, 1000, 2);
		set_window(1023);
		set_window(512);
		send_item(OP_QUERY, 2000, 100, 1);
		set_window(1);
		send_item(OP_QUERY, 2000, 100, 1);
		send_item(OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 5);
	endtask

	task automatic test_saturation();
		send_item(OP_CLEAR, 0, 0, 0);
		send_item(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 0);
		send_item(OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_item(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_item(OP_CLOSE, 0, 0, 0);
		send_item(OP_QUERY, 0, 0, 1);
	endtask

	task automatic test_table_full();
		set_window(2);
		send_item(OP_CLEAR, 0, 0, 0);
		for (int k = 0; k < MAX_STATIONS_DEF; k++)
			send_item(OP_APPEND, k * 512 + $urandom_range(255),
				$urandom_range(4095) - 2048, 0);
		send_item(OP_APPEND, 5, 5, 0);
		send_item(OP_CLOSE, 0, 0, 0);
		send_item(OP_QUERY, 1023 * 512, 100, 1023);
	endtask

	task automatic test_output_stall();
		send_item(OP_CLEAR, 0, 0, 0);
		drain();
		hold_cycles = 3000;
		for (int k = 0; k < 8; k++)
			send_item(OP_APPEND, $urandom_range(65535), $urandom_range(65535), 0);
		send_item(OP_CLOSE, 0, 0, 0);
		drain();
	endtask

	function automatic int rand_coord(int spread);
		return $urandom_range(2 * spread) - spread;
	endfunction

	task automatic random_loop(int spread);
		int n;
		int pick;
		int x;
		int z;
		send_item(OP_CLEAR, 0, 0, 0);
		n = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(3, 10);
		for (int k = 0; k < n; k++) begin
			if (k > 0 && $urandom_range(15) == 0)
				send_item(OP_APPEND, stn_x[stn_count - 1], stn_z[stn_count - 1], 0);
			else
				send_item(OP_APPEND, rand_coord(spread), rand_coord(spread), 0);
		end
		send_item(OP_CLOSE, 0, 0, 0);
		repeat ($urandom_range(4, 12)) begin
			if ($urandom_range(9) == 0) begin
				send_item(OP_QUERY, $urandom, $urandom, $urandom_range(1023));
			end else begin
				pick = $urandom_range(stn_count - 1);
				x = stn_x[pick] + rand_coord(spread / 4 + 1);
				z = stn_z[pick] + rand_coord(spread / 4 + 1);
				send_item(OP_QUERY, x, z, ($urandom_range(3) == 0) ?
					$urandom_range(1023) : pick + $urandom_range(2));
			end
		end
	endtask

	task automatic random_noise();
		logic [1:0] op;
		op = $urandom_range(3);
		send_item(op, $urandom, $urandom, $urandom_range(1023));
	endtask

	task automatic test_random_phase(int src_pct, int snk_pct, int count);
		int stop_at;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(5) == 0)
				set_window($urandom_range(3) == 0 ? $urandom_range(0, 4) : $urandom_range(1, 2));
			if ($urandom_range(9) == 0)
				random_noise();
			else
				random_loop(($urandom_range(7) == 0) ? 32'h3FFF_FFFF : (1 << $urandom_range(8, 24)));
		end
	endtask

	initial begin
		errors = 0;
		answers_seen = 0;
		items_sent = 0;
		queries_sent = 0;
		hold_cycles = 0;
		src_idle_pct = 37;
		snk_idle_pct = 75;
		stn_count = 0;
		lap_len = 0;
		lap_done = 0;
		window = 2;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req.valid <= 1'b0;
		req.op <= OP_CLEAR;
		req.pos_x <= '0;
		req.pos_z <= '0;
		req.hint_station <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unloaded_map();
		test_square_loop();
		test_window_extremes();
		test_saturation();
		test_output_stall();
		test_table_full();
		test_random_phase(37, 75, 150);
		test_random_phase(75, 37, 150);
		test_random_phase(0, 0, 150);
		drain();
		repeat (20) @(posedge clk);

		$display("sent %0d items (%0d queries), checked %0d results", items_sent,
			queries_sent, answers_seen);
		$display("covered unloaded map, saturation, full table, window extremes, stalls");
		if (errors == 0)
			$display("tb_closed_polyline_arc_projection: PASS");
		else
			$display("tb_closed_polyline_arc_projection: FAIL");
		$finish;
	end

endmodule
